[design/rlpm_pkg.sv]
// Shared types and codes for the IPv4 longest-prefix-match route lookup.
// No dependencies.
package rlpm_pkg;

    localparam logic ACT_WRITE   = 1'b0;
    localparam logic ACT_LOOKUP  = 1'b1;
    localparam logic TBL_STATIC  = 1'b0;
    localparam logic TBL_DYNAMIC = 1'b1;

    typedef struct packed {
        logic        action;
        logic        table_select;
        logic [3:0]  entry_index;
        logic        entry_valid;
        logic [31:0] entry_prefix;
        logic [31:0] entry_mask;
        logic [31:0] entry_next_hop;
        logic [1:0]  entry_port;
        logic [31:0] lookup_addr;
    } req_t;

    typedef struct packed {
        logic        hit;
        logic        from_dynamic;
        logic [1:0]  out_port;
        logic [31:0] out_next_hop;
        logic [3:0]  out_index;
    } rsp_t;

    typedef struct packed {
        logic [31:0] prefix;
        logic [31:0] mask;
        logic [31:0] gateway;
        logic [1:0]  port;
    } entry_t;

    // table write command
    typedef struct packed {
        logic load;
        logic clear;
    } wr_cmd_t;

endpackage

[design/rlpm_table.sv]
// Route entry memory (static slots first, then dynamic) with per-slot valid bits.
// Depends on rlpm_pkg.
module rlpm_table
    import rlpm_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16,
    parameter int AW = 5
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  wr_cmd_t wr_cmd,
    input  logic [AW-1:0] wr_addr,
    input  entry_t  wr_data,
    input  logic    rd_en,
    input  logic [AW-1:0] rd_addr,
    output entry_t  rd_data,
    output logic    rd_valid
);

    localparam int SLOTS = 2 * TABLE_ENTRIES;

    entry_t           mem [SLOTS];
    logic [SLOTS-1:0] valid_reg;
    entry_t           rd_data_reg;
    logic             rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_cmd.load)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_cmd.load)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            else if (wr_cmd.clear)
            begin
                valid_reg[wr_addr] <= 1'b0;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data  = rd_data_reg;
    assign rd_valid = rd_valid_reg;

endmodule

[design/rlpm_ctrl.sv]
// Command decode, table scan sequencer and best-match tracking.
// Depends on rlpm_pkg; drives rlpm_table.
module rlpm_ctrl
    import rlpm_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16,
    parameter int PORT_COUNT = 4,
    parameter int AW = 5
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  req_t    req,
    output logic    done,
    output rsp_t    rsp,
    output wr_cmd_t wr_cmd,
    output logic [AW-1:0] wr_addr,
    output entry_t  wr_data,
    output logic    rd_en,
    output logic [AW-1:0] rd_addr,
    input  entry_t  rd_data,
    input  logic    rd_valid
);

    localparam int XW = AW + 5;
    localparam logic [AW-1:0] LAST_SLOT = AW'(2 * TABLE_ENTRIES - 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_LAST = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t      state_reg, state_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic        pend_reg;
    logic [AW-1:0] slot_reg;
    logic [31:0] addr_reg;
    logic        found_reg, found_next;
    logic        best_dyn_reg;
    logic [31:0] best_mask_reg;
    logic [3:0]  best_idx_reg;
    logic [31:0] best_nhop_reg;
    logic [1:0]  best_port_reg;

    logic          accept;
    logic [XW-1:0] wr_sum;
    logic          idx_ok;
    logic          port_ok;
    logic          is_dyn;
    logic [AW-1:0] tbl_idx;
    logic [AW+3:0] tbl_idx_ext;
    logic          match;
    logic          take;

    assign busy   = !(state_reg == S_IDLE || state_reg == S_OUT);
    assign accept = start && !busy;

    // write decode
    assign wr_sum  = XW'(req.entry_index)
                   + ((req.table_select == TBL_DYNAMIC) ? XW'(TABLE_ENTRIES) : XW'(0));
    assign idx_ok  = XW'(req.entry_index) < XW'(TABLE_ENTRIES);
    assign port_ok = 5'(req.entry_port) < 5'(PORT_COUNT);
    assign wr_addr = wr_sum[AW-1:0];
    assign wr_data = '{prefix: req.entry_prefix, mask: req.entry_mask,
                       gateway: req.entry_next_hop, port: req.entry_port};

    always_comb
    begin
        wr_cmd = '0;
        if (accept && req.action == ACT_WRITE && idx_ok)
        begin
            wr_cmd.clear = !req.entry_valid;
            wr_cmd.load  = req.entry_valid && port_ok;
        end
    end

    // scan read issue
    assign rd_en   = (state_reg == S_SCAN);
    assign rd_addr = cnt_reg;

    // compare stage on returned entry
    assign is_dyn      = slot_reg >= AW'(TABLE_ENTRIES);
    assign tbl_idx     = is_dyn ? slot_reg - AW'(TABLE_ENTRIES) : slot_reg;
    assign tbl_idx_ext = {4'b0000, tbl_idx};
    assign match       = pend_reg && rd_valid
                       && ((rd_data.mask & addr_reg) == rd_data.prefix);
    assign take        = match && (!found_reg || (is_dyn && !best_dyn_reg)
                       || (best_mask_reg <= rd_data.mask));

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        found_next = found_reg || take;
        case (state_reg)
            S_IDLE, S_OUT:
            begin
                state_next = S_IDLE;
                if (accept && req.action == ACT_LOOKUP)
                begin
                    state_next = S_SCAN;
                    cnt_next   = '0;
                    found_next = 1'b0;
                end
            end
            S_SCAN:
            begin
                cnt_next = cnt_reg + AW'(1);
                if (cnt_reg == LAST_SLOT)
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                state_next = S_OUT;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= rd_en;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= cnt_reg;
        if (accept && req.action == ACT_LOOKUP)
        begin
            addr_reg <= req.lookup_addr;
        end
        if (take)
        begin
            best_dyn_reg  <= is_dyn;
            best_mask_reg <= rd_data.mask;
            best_idx_reg  <= tbl_idx_ext[3:0];
            best_nhop_reg <= rd_data.gateway;
            best_port_reg <= rd_data.port;
        end
    end

    assign done = (state_reg == S_OUT);

    always_comb
    begin
        rsp = '0;
        if (found_reg)
        begin
            rsp.hit          = 1'b1;
            rsp.from_dynamic = best_dyn_reg;
            rsp.out_port     = best_port_reg;
            rsp.out_next_hop = best_nhop_reg;
            rsp.out_index    = best_idx_reg;
        end
    end

endmodule

[design/route_longest_prefix_lookup.sv]
// Lookup: after accept, S_SCAN steps over all slots, then S_LAST, then S_OUT with done shown;
// S_SCAN reads both tables one slot per cycle through the single memory read port.
// A new transaction is accepted in the cycle that done is shown.
// A write completes at its accept edge; busy stays low. Results cannot be stalled.
// Reset clears all valid bits at once; entry contents are undefined until written.
module route_longest_prefix_lookup
    import rlpm_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16,
    parameter int PORT_COUNT = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t req,
    output logic done,
    output rsp_t rsp
);

    localparam int AW = $clog2(2 * TABLE_ENTRIES);

    wr_cmd_t       wr_cmd;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    entry_t        rd_data;
    logic          rd_valid;

    rlpm_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .PORT_COUNT    (PORT_COUNT),
        .AW            (AW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req      (req),
        .done     (done),
        .rsp      (rsp),
        .wr_cmd   (wr_cmd),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .rd_valid (rd_valid)
    );

    rlpm_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .AW            (AW)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_cmd   (wr_cmd),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .rd_valid (rd_valid)
    );

endmodule

[bench/testbench.sv]
// Testbench for route_longest_prefix_lookup: directed table rows, then random route writes
// and lookups, each result checked against a given value or a two-table longest-prefix predictor.
// Depends on rlpm_pkg and the route_longest_prefix_lookup RTL.
module testbench;
    import rlpm_pkg::*;

    localparam int TABLE_ENTRIES = 16;
    localparam int PORT_COUNT = 4;
    localparam int SLOTS = 2 * TABLE_ENTRIES;
    localparam int RANDOM_ITEMS = 1000;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DIRECTED_ROWS = 24;

    localparam rsp_t NO_ROUTE = '0;
    localparam rsp_t DEFAULT_ROUTE = '{hit: 1'b1, from_dynamic: 1'b0, out_port: 2'd3,
                                       out_next_hop: 32'hFFFF_FFFF, out_index: 4'd0};

    typedef struct {
        req_t item;
        bit   typed;
        rsp_t want;
    } step_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t req = '0;
    logic busy;
    logic done;
    rsp_t rsp;

    entry_t      rt_tbl [SLOTS];
    bit          rt_valid [SLOTS];
    logic [31:0] net_base [4];
    rsp_t        route_expect_q [$];
    step_t       directed [DIRECTED_ROWS];
    int          mismatches = 0;
    int          quiet_cycles = 0;
    bit          no_idle = 1'b0;

    route_longest_prefix_lookup #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .PORT_COUNT(PORT_COUNT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .req(req),
        .done(done),
        .rsp(rsp)
    );

    always #10 clk = ~clk;

    function automatic void store_route(input req_t w);
        int slot;
        if (int'(w.entry_index) >= TABLE_ENTRIES)
            return;
        slot = int'(w.table_select) * TABLE_ENTRIES + int'(w.entry_index);
        if (!w.entry_valid)
        begin
            rt_valid[slot] = 1'b0;
            return;
        end
        if (int'(w.entry_port) >= PORT_COUNT)
            return;
        rt_tbl[slot] = '{prefix: w.entry_prefix, mask: w.entry_mask,
                         gateway: w.entry_next_hop, port: w.entry_port};
        rt_valid[slot] = 1'b1;
    endfunction

    function automatic rsp_t best_route(input logic [31:0] addr);
        rsp_t        r;
        int          tbl;
        int          i;
        int          slot;
        int          best;
        bit          found;
        logic [31:0] best_mask;
        r = NO_ROUTE;
        // dynamic table first, static only on a dynamic miss
        for (tbl = 1; tbl >= 0; tbl--)
        begin
            found = 1'b0;
            best = 0;
            best_mask = '0;
            for (i = 0; i < TABLE_ENTRIES; i++)
            begin
                slot = tbl * TABLE_ENTRIES + i;
                if (rt_valid[slot] && (rt_tbl[slot].mask & addr) == rt_tbl[slot].prefix
                    && (!found || best_mask <= rt_tbl[slot].mask))
                begin
                    found = 1'b1;
                    best_mask = rt_tbl[slot].mask;
                    best = i;
                end
            end
            if (found)
            begin
                slot = tbl * TABLE_ENTRIES + best;
                r.hit = 1'b1;
                r.from_dynamic = (tbl == int'(TBL_DYNAMIC));
                r.out_port = rt_tbl[slot].port;
                r.out_next_hop = rt_tbl[slot].gateway;
                r.out_index = best[3:0];
                return r;
            end
        end
        return r;
    endfunction

    function automatic req_t write_req(input logic tsel, input logic [3:0] idx,
                                       input logic valid, input logic [31:0] prefix,
                                       input logic [31:0] mask, input logic [31:0] hop,
                                       input logic [1:0] port);
        req_t r;
        r = '0;
        r.action = ACT_WRITE;
        r.table_select = tsel;
        r.entry_index = idx;
        r.entry_valid = valid;
        r.entry_prefix = prefix;
        r.entry_mask = mask;
        r.entry_next_hop = hop;
        r.entry_port = port;
        return r;
    endfunction

    function automatic req_t lookup_req(input logic [31:0] addr);
        req_t r;
        r = '0;
        r.action = ACT_LOOKUP;
        r.lookup_addr = addr;
        return r;
    endfunction

    function automatic req_t random_fields();
        req_t r;
        r.action = 1'($urandom_range(0, 1));
        r.table_select = 1'($urandom_range(0, 1));
        r.entry_index = 4'($urandom_range(0, 15));
        r.entry_valid = 1'($urandom_range(0, 1));
        r.entry_prefix = $urandom;
        r.entry_mask = $urandom;
        r.entry_next_hop = $urandom;
        r.entry_port = 2'($urandom_range(0, 3));
        r.lookup_addr = $urandom;
        return r;
    endfunction

    function automatic req_t random_write();
        req_t w;
        int   len;
        w = random_fields();
        w.action = ACT_WRITE;
        w.entry_valid = ($urandom_range(0, 6) != 0);
        len = $urandom_range(0, 32);
        if ($urandom_range(0, 9) != 0)
            w.entry_mask = 32'hFFFF_FFFF << (32 - len);
        // mostly nested subnets of a few networks so lookups overlap
        if ($urandom_range(0, 9) != 0)
            w.entry_prefix = (net_base[$urandom_range(0, 3)]
                              ^ (32'($urandom_range(0, 255)) << 8)) & w.entry_mask;
        return w;
    endfunction

    function automatic req_t random_lookup();
        req_t r;
        int   pick;
        int   slot;
        r = random_fields();
        r.action = ACT_LOOKUP;
        pick = $urandom_range(0, 9);
        slot = $urandom_range(0, SLOTS - 1);
        if (pick < 5 && rt_valid[slot])
            r.lookup_addr = (rt_tbl[slot].prefix & rt_tbl[slot].mask)
                            | (r.lookup_addr & ~rt_tbl[slot].mask);
        else if (pick < 8)
            r.lookup_addr = net_base[$urandom_range(0, 3)] ^ ($urandom & 32'h0000_FFFF);
        return r;
    endfunction

    task automatic issue(input req_t item, input bit typed, input rsp_t want);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req <= item;
        do @(posedge clk); while (busy);
        if (item.action == ACT_WRITE)
            store_route(item);
        else
            route_expect_q.push_back(typed ? want : best_route(item.lookup_addr));
    endtask

    task automatic drain_routes();
        start <= 1'b0;
        @(posedge clk);
        while (route_expect_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s expected %h got %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && done)
        begin
            if (route_expect_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: result expected none got %h", $time, rsp);
            end
            else
            begin
                want = route_expect_q.pop_front();
                check_field("hit", want.hit, rsp.hit);
                check_field("from_dynamic", want.from_dynamic, rsp.from_dynamic);
                check_field("out_port", want.out_port, rsp.out_port);
                check_field("out_next_hop", want.out_next_hop, rsp.out_next_hop);
                check_field("out_index", want.out_index, rsp.out_index);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial
    begin
        int n;
        net_base[0] = $urandom;
        net_base[1] = net_base[0] ^ 32'h0000_0100;
        net_base[2] = $urandom;
        net_base[3] = net_base[2] & 32'hFFFF_0000;
        directed = '{
            '{lookup_req(32'h0000_0000), 1'b1, NO_ROUTE},
            '{lookup_req(32'hFFFF_FFFF), 1'b1, NO_ROUTE},
            '{write_req(TBL_STATIC, 4'd0, 1'b1, 32'h0, 32'h0, 32'hFFFF_FFFF, 2'd3), 1'b0, NO_ROUTE},
            '{lookup_req(32'hFFFF_FFFF), 1'b1, DEFAULT_ROUTE},
            '{lookup_req(32'h0000_0000), 1'b1, DEFAULT_ROUTE},
            '{write_req(TBL_STATIC, 4'd15, 1'b1, 32'hC0A8_0000, 32'hFFFF_0000,
                        32'h0A00_0001, 2'd1), 1'b0, NO_ROUTE},
            '{write_req(TBL_STATIC, 4'd3, 1'b1, 32'hC0A8_0000, 32'hFFFF_0000,
                        32'h0A00_0003, 2'd2), 1'b0, NO_ROUTE},
            // equal masks: higher slot wins
            '{lookup_req(32'hC0A8_1234), 1'b0, NO_ROUTE},
            '{write_req(TBL_DYNAMIC, 4'd0, 1'b1, 32'hC0A8_1200, 32'hFFFF_FF00,
                        32'h0A00_00FE, 2'd0), 1'b0, NO_ROUTE},
            '{lookup_req(32'hC0A8_1234), 1'b0, NO_ROUTE},
            '{lookup_req(32'h0A00_0000), 1'b0, NO_ROUTE},
            // dynamic default route beats a longer static match
            '{write_req(TBL_DYNAMIC, 4'd7, 1'b1, 32'h0, 32'h0, 32'h0101_0101, 2'd3), 1'b0, NO_ROUTE},
            '{lookup_req(32'hC0A8_FF00), 1'b0, NO_ROUTE},
            // non-contiguous mask ranked by value
            '{write_req(TBL_DYNAMIC, 4'd15, 1'b1, 32'h0000_0001, 32'h8000_0001,
                        32'h0, 2'd2), 1'b0, NO_ROUTE},
            '{lookup_req(32'h0000_0001), 1'b0, NO_ROUTE},
            // removal clears only the valid bit
            '{write_req(TBL_DYNAMIC, 4'd7, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        32'hFFFF_FFFF, 2'd0), 1'b0, NO_ROUTE},
            '{lookup_req(32'h0A00_0000), 1'b0, NO_ROUTE},
            '{write_req(TBL_STATIC, 4'd8, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        32'h1234_5678, 2'd1), 1'b0, NO_ROUTE},
            '{lookup_req(32'hFFFF_FFFF), 1'b0, NO_ROUTE},
            '{write_req(TBL_STATIC, 4'd15, 1'b0, 32'h0, 32'h0, 32'h0, 2'd0), 1'b0, NO_ROUTE},
            '{lookup_req(32'hC0A8_FF00), 1'b0, NO_ROUTE},
            '{write_req(TBL_DYNAMIC, 4'd0, 1'b0, 32'h0, 32'h0, 32'h0, 2'd0), 1'b0, NO_ROUTE},
            '{write_req(TBL_DYNAMIC, 4'd15, 1'b0, 32'h0, 32'h0, 32'h0, 2'd0), 1'b0, NO_ROUTE},
            '{lookup_req(32'hC0A8_1234), 1'b0, NO_ROUTE}
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (n = 0; n < DIRECTED_ROWS; n++)
            issue(directed[n].item, directed[n].typed, directed[n].want);
        drain_routes();

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if ($urandom_range(0, 39) == 0)
                no_idle = !no_idle;
            if (n % 250 == 249)
                drain_routes();
            if ($urandom_range(0, 99) < 35)
                issue(random_write(), 1'b0, NO_ROUTE);
            else
                issue(random_lookup(), 1'b0, NO_ROUTE);
        end

        drain_routes();
        repeat (40) @(posedge clk);
        if (mismatches == 0 && route_expect_q.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
